FILE: rtl/core/bcdc_pkg.sv
`timescale 1ns / 1ps

package bcdc_pkg;

  localparam int WORD_W     = 32;
  localparam int NIB_W      = 4;
  localparam int NIBBLES    = WORD_W / NIB_W;
  localparam int DIGITS_DEF = 8;
  localparam int PROD_W     = 2 * WORD_W;

  // floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
  localparam logic [WORD_W-1:0] RECIP       = 32'hCCCC_CCCD;
  localparam int                RECIP_SHIFT = 35;

  localparam logic [NIB_W-1:0] DIGIT_MAX = 4'd9;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // one transaction in flight along the chain
  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] work;  // running quotient (encode) or running sum (decode)
    logic [WORD_W-1:0] word;  // packed digits so far (encode) or input word (decode)
  } bcdc_item_t;

endpackage

FILE: rtl/core/bcd_convert_8_digit_core.sv
`timescale 1ns / 1ps

// channel  | ports                          | payload
// ---------+--------------------------------+--------------------------------------
// input    | in_tvalid in_tready            | in_tuser = func, in_tdata = value
// output   | out_tvalid out_tready          | out_tdata = result
//
// a row of DIGITS cells, one decimal digit per cell; a transaction moves one
// cell per cycle unless stalled, and one transaction per cycle is accepted
// while in_tready is high. the 32x32 reciprocal multiply inside each cell
// sets the clock. rst_n (synchronous, active low) clears the cell valid bits only.
// each cell stalls on its own: ready ripples back from out_tready, and empty
// cells keep filling while a finished result waits at the output register.
module bcd_convert_8_digit_core #(
  parameter int DIGITS = bcdc_pkg::DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_tuser,   // [0] func
  input  logic [bcdc_pkg::WORD_W-1:0] in_tdata,   // [31:0] value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bcdc_pkg::WORD_W-1:0] out_tdata   // [31:0] result
);
  import bcdc_pkg::*;

  // chain links: link k feeds cell k, link DIGITS is the output register
  logic       link_valid [DIGITS+1];
  logic       link_ready [DIGITS+1];
  bcdc_item_t link_item  [DIGITS+1];

  // encode starts with the whole value as quotient, decode with a zero sum
  always_comb begin
    link_item[0].func = in_tuser;
    if (in_tuser == FUNC_DECODE) begin
      link_item[0].work = '0;
      link_item[0].word = in_tdata;
    end else begin
      link_item[0].work = in_tdata;
      link_item[0].word = '0;
    end
  end

  assign link_valid[0] = in_tvalid;
  assign in_tready     = link_ready[0];

  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    bcdc_cell #(
      .DIGITS (DIGITS),
      .INDEX  (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[k]),
      .up_ready (link_ready[k]),
      .up_item  (link_item[k]),
      .dn_valid (link_valid[k+1]),
      .dn_ready (link_ready[k+1]),
      .dn_item  (link_item[k+1])
    );
  end

  // the last cell's register is the output register
  assign out_tvalid         = link_valid[DIGITS];
  assign link_ready[DIGITS] = out_tready;
  assign out_tdata          = (link_item[DIGITS].func == FUNC_DECODE) ?
                              link_item[DIGITS].work : link_item[DIGITS].word;

  // every nibble of an encoded word is a decimal digit
  logic enc_ok;
  always_comb begin
    enc_ok = 1'b1;
    for (int i = 0; i < NIBBLES; i++) begin
      if (link_item[DIGITS].word[NIB_W*i +: NIB_W] > DIGIT_MAX) begin
        enc_ok = 1'b0;
      end
    end
  end

  a_enc_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && link_item[DIGITS].func == FUNC_ENCODE) |-> enc_ok)
    else $error("encoded result holds a nibble above nine");

  // decode sum never exceeds 15 * 11111111, well under 2**28
  a_dec_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && link_item[DIGITS].func == FUNC_DECODE) |->
      (out_tdata[WORD_W-1:WORD_W-NIB_W] == '0))
    else $error("decoded result out of range");

  // a free output slot must reach the input through the ready chain
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled although the chain can move");

endmodule

FILE: rtl/core/bcdc_cell.sv
`timescale 1ns / 1ps

module bcdc_cell #(
  parameter int DIGITS = bcdc_pkg::DIGITS_DEF,
  parameter int INDEX  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  bcdc_pkg::bcdc_item_t up_item,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output bcdc_pkg::bcdc_item_t dn_item
);
  import bcdc_pkg::*;

  // encode peels digit INDEX, decode folds in nibbles from the top down
  localparam int ENC_POS = NIB_W * INDEX;
  localparam int DEC_POS = NIB_W * (DIGITS - 1 - INDEX);

  logic              valid_r;
  logic              valid_nxt;
  bcdc_item_t        item_r;
  bcdc_item_t        item_nxt;
  logic [PROD_W-1:0] prod;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] rem_full;
  logic [NIB_W-1:0]  nib;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    prod     = {{(PROD_W-WORD_W){1'b0}}, up_item.work} * {{(PROD_W-WORD_W){1'b0}}, RECIP};
    quo      = WORD_W'(prod >> RECIP_SHIFT);
    rem_full = up_item.work - (quo << 3) - (quo << 1);
    nib      = up_item.word[DEC_POS +: NIB_W];
    item_nxt = up_item;
    if (up_item.func == FUNC_DECODE) begin
      item_nxt.work = (up_item.work << 3) + (up_item.work << 1)
                    + {{(WORD_W-NIB_W){1'b0}}, nib};
    end else begin
      item_nxt.work = quo;
      item_nxt.word = up_item.word
                    | ({{(WORD_W-NIB_W){1'b0}}, rem_full[NIB_W-1:0]} << ENC_POS);
    end
  end

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule
